// File: src/abbi_pkg.sv
package abbi_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_BOX    = 31;

  localparam int DIM_W   = 11;  // image_width / image_height register width
  localparam int COL_W   = 10;  // column position, 0 .. MAX_WIDTH-1
  localparam int HALF_W  = 4;   // half box side
  localparam int SUM_W   = 28;  // prefix sums, modulo 2^28
  localparam int LIN_W   = 21;  // linear pixel count, up to MAX_WIDTH*MAX_HEIGHT
  localparam int AREA_W  = 10;  // box area, up to MAX_BOX*MAX_BOX
  localparam int DIV_K   = 18;  // reciprocal scale; window sums stay below 2^DIV_K
  localparam int RECIP_W = DIV_K + 1;
  localparam int PROD_W  = DIV_K + RECIP_W;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // oldest entry still read lies at most MAX_BOX*(MAX_WIDTH+1) behind the newest write
  localparam int RING_SPAN = MAX_BOX * (MAX_WIDTH + 1);
  localparam int RAM_AW    = $clog2(RING_SPAN + 1);
  localparam int RAM_DEPTH = 1 << RAM_AW;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_DRAIN  = 1'b1;

  localparam logic [1:0] REG_BLUR   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_WRITE,
    ST_WIN,
    ST_RD,
    ST_RD_LAST,
    ST_DIV0,
    ST_DIV1,
    ST_EMIT
  } state_t;

  // floor(2^DIV_K / side^2) for side = 2*half+1
  function automatic logic [RECIP_W-1:0] area_recip(input logic [HALF_W-1:0] half);
    logic [RECIP_W-1:0] r;
    unique case (half)
      4'd0:  r = 19'd262144;
      4'd1:  r = 19'd29127;
      4'd2:  r = 19'd10485;
      4'd3:  r = 19'd5349;
      4'd4:  r = 19'd3236;
      4'd5:  r = 19'd2166;
      4'd6:  r = 19'd1551;
      4'd7:  r = 19'd1165;
      4'd8:  r = 19'd907;
      4'd9:  r = 19'd726;
      4'd10: r = 19'd594;
      4'd11: r = 19'd495;
      4'd12: r = 19'd419;
      4'd13: r = 19'd359;
      4'd14: r = 19'd311;
      4'd15: r = 19'd272;
    endcase
    return r;
  endfunction

endpackage

// File: src/abbi_ram.sv
module abbi_ram #(
  parameter int WIDTH = 28,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// File: src/alpha_box_blur_integral.sv
// a sample that completes a window passes decide, write, window setup, four window reads,
// a wait for the last read, a divide step, a correction step and emit; a drain that completes
// one skips the write; a sample without a result ends after the write, an ignored drain after
// decide; the input stays stalled until idle again and a stalled result holds back the next one;
// all this is set by the single port of the prefix ring (row read, write, four window reads)
// reset (synchronous): positions, row sum, handshake and blur clear, width and height go to
// the maximum; the prefix ring is not cleared, every entry whose value is used is written first
module alpha_box_blur_integral import abbi_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_opcode,
  input  logic [7:0]         in_alpha_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_alpha_out,
  output logic               out_frame_last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam logic [DIM_W-1:0] W_MAX = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] H_MAX = DIM_W'(MAX_HEIGHT);
  localparam logic [DIM_W-1:0] DIM_ONE = DIM_W'(1);

  // configuration
  logic [7:0]       blur_r;
  logic [DIM_W-1:0] width_r, height_r;
  logic             cfg_wr;

  // derived from configuration
  logic [DIM_W-1:0]   w_r, h_r, w_c, h_c;
  logic [HALF_W-1:0]  half_r;
  logic [LIN_W-1:0]   lag_r, total_r;
  logic [AREA_W-1:0]  area_r;
  logic [RECIP_W-1:0] recip_r;
  logic [RAM_AW-1:0]  rowoff_lo_r;
  logic [4:0]         side_c;

  state_t state_r, state_nxt;

  logic             op_r;
  logic [7:0]       alpha_r;
  logic [COL_W-1:0] in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [DIM_W-1:0] in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [LIN_W-1:0] in_lin_r, in_lin_nxt, out_lin_r, out_lin_nxt;
  logic [SUM_W-1:0] row_sum_r, row_sum_nxt;

  logic [HALF_W-1:0] dk2_r, dk2_nxt, di2_r, di2_nxt;
  logic              has_k1_r, has_k1_nxt, has_i1_r, has_i1_nxt;
  logic [RAM_AW-1:0] rowoff_hi_r, rowoff_hi_nxt;
  logic [1:0]        rd_idx_r, rd_idx_nxt, acc_idx_r, acc_idx_nxt;
  logic              acc_vld_r, acc_vld_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic              sat_r, sat_nxt;
  logic [7:0]        q0_r, q0_nxt, res_r, res_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_alpha_r, out_alpha_nxt;
  logic       out_last_r, out_last_nxt;

  logic              ram_we;
  logic [RAM_AW-1:0] ram_addr;
  logic [SUM_W-1:0]  ram_wdata, ram_rdata;

  // combinational helpers
  logic [DIM_W-1:0]  rows_below, cols_right;
  logic [HALF_W-1:0] dk2_c, di2_c;
  logic [RAM_AW-1:0] row_term, col_term;
  logic [PROD_W-1:0] div_prod;
  logic [DIV_K-1:0]  qd, rem;
  logic              frame_last_c;

  abbi_ram #(
    .WIDTH(SUM_W),
    .DEPTH(RAM_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  // configuration port
  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[3:2])
      REG_BLUR:   prdata = PDATA_W'(blur_r);
      REG_WIDTH:  prdata = PDATA_W'(width_r);
      REG_HEIGHT: prdata = PDATA_W'(height_r);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blur_r   <= '0;
      width_r  <= W_MAX;
      height_r <= H_MAX;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_BLUR:   blur_r   <= pwdata[7:0];
        REG_WIDTH:  width_r  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: height_r <= pwdata[DIM_W-1:0];
        default:    ;
      endcase
    end
  end

  assign w_c = (width_r == '0) ? DIM_ONE : ((width_r > W_MAX) ? W_MAX : width_r);
  assign h_c = (height_r == '0) ? DIM_ONE : ((height_r > H_MAX) ? H_MAX : height_r);
  // side = (blur/8)|1, which never exceeds MAX_BOX
  assign side_c = {blur_r[7:4], 1'b1};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r         <= W_MAX;
      h_r         <= H_MAX;
      half_r      <= '0;
      lag_r       <= '0;
      total_r     <= LIN_W'(MAX_WIDTH * MAX_HEIGHT);
      area_r      <= AREA_W'(1);
      recip_r     <= area_recip('0);
      rowoff_lo_r <= RAM_AW'(MAX_WIDTH);
    end else begin
      w_r         <= w_c;
      h_r         <= h_c;
      half_r      <= blur_r[7:4];
      lag_r       <= LIN_W'(blur_r[7:4]) * (LIN_W'(w_c) + LIN_W'(1));
      total_r     <= LIN_W'(w_c) * LIN_W'(h_c);
      area_r      <= AREA_W'(side_c) * AREA_W'(side_c);
      recip_r     <= area_recip(blur_r[7:4]);
      rowoff_lo_r <= (RAM_AW'(blur_r[7:4]) + RAM_AW'(1)) * RAM_AW'(w_c);
    end
  end

  // window geometry
  assign rows_below = h_r - DIM_ONE - out_row_r;
  assign cols_right = w_r - DIM_ONE - DIM_W'(out_col_r);
  assign dk2_c = (rows_below > DIM_W'(half_r)) ? half_r : rows_below[HALF_W-1:0];
  assign di2_c = (cols_right > DIM_W'(half_r)) ? half_r : cols_right[HALF_W-1:0];

  // far rows and columns lie behind the output pixel
  assign row_term = rd_idx_r[1] ? (RAM_AW'(0) - rowoff_lo_r) : rowoff_hi_r;
  assign col_term = rd_idx_r[0] ? (RAM_AW'(0) - RAM_AW'(half_r) - RAM_AW'(1))
                                : RAM_AW'(di2_r);

  assign div_prod = PROD_W'(sum_r[DIV_K-1:0]) * PROD_W'(recip_r);
  assign qd       = DIV_K'(q0_r) * DIV_K'(area_r);
  assign rem      = sum_r[DIV_K-1:0] - qd;

  assign frame_last_c = (out_lin_r == total_r - LIN_W'(1));

  always_comb begin
    state_nxt     = state_r;
    in_col_nxt    = in_col_r;
    in_row_nxt    = in_row_r;
    in_lin_nxt    = in_lin_r;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    out_lin_nxt   = out_lin_r;
    row_sum_nxt   = row_sum_r;
    dk2_nxt       = dk2_r;
    di2_nxt       = di2_r;
    has_k1_nxt    = has_k1_r;
    has_i1_nxt    = has_i1_r;
    rowoff_hi_nxt = rowoff_hi_r;
    rd_idx_nxt    = rd_idx_r;
    acc_vld_nxt   = 1'b0;
    acc_idx_nxt   = rd_idx_r;
    sum_nxt       = sum_r;
    sat_nxt       = sat_r;
    q0_nxt        = q0_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_alpha_nxt = out_alpha_r;
    out_last_nxt  = out_last_r;
    ram_we        = 1'b0;
    ram_addr      = in_lin_r[RAM_AW-1:0];
    ram_wdata     = row_sum_r + ((in_row_r != '0) ? ram_rdata : '0);

    // window reads land in the cycle after their address
    if (acc_vld_r) begin
      unique case (acc_idx_r)
        2'd0: sum_nxt = sum_r + ram_rdata;
        2'd1: if (has_i1_r) sum_nxt = sum_r - ram_rdata;
        2'd2: if (has_k1_r) sum_nxt = sum_r - ram_rdata;
        2'd3: if (has_k1_r && has_i1_r) sum_nxt = sum_r + ram_rdata;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (in_row_r >= h_r) begin
          state_nxt = ST_WIN;
        end else if (op_r == OP_DRAIN) begin
          state_nxt = ST_IDLE;
        end else begin
          row_sum_nxt = ((in_col_r == '0) ? '0 : row_sum_r) + SUM_W'(alpha_r);
          // prefix of the same column one row up
          ram_addr  = in_lin_r[RAM_AW-1:0] - RAM_AW'(w_r);
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        ram_we     = 1'b1;
        in_lin_nxt = in_lin_r + LIN_W'(1);
        if (DIM_W'(in_col_r) + DIM_ONE >= w_r) begin
          in_col_nxt = '0;
          in_row_nxt = in_row_r + DIM_ONE;
        end else begin
          in_col_nxt = in_col_r + COL_W'(1);
        end
        state_nxt = (in_lin_r >= out_lin_r + lag_r) ? ST_WIN : ST_IDLE;
      end
      ST_WIN: begin
        dk2_nxt       = dk2_c;
        di2_nxt       = di2_c;
        has_k1_nxt    = out_row_r > DIM_W'(half_r);
        has_i1_nxt    = out_col_r > COL_W'(half_r);
        rowoff_hi_nxt = RAM_AW'(dk2_c) * RAM_AW'(w_r);
        rd_idx_nxt    = '0;
        sum_nxt       = '0;
        state_nxt     = ST_RD;
      end
      ST_RD: begin
        ram_addr    = out_lin_r[RAM_AW-1:0] + row_term + col_term;
        acc_vld_nxt = 1'b1;
        acc_idx_nxt = rd_idx_r;
        rd_idx_nxt  = rd_idx_r + 2'd1;
        if (rd_idx_r == 2'd3) state_nxt = ST_RD_LAST;
      end
      ST_RD_LAST: begin
        state_nxt = ST_DIV0;
      end
      ST_DIV0: begin
        sat_nxt   = sum_r >= SUM_W'({area_r, 8'h00});
        q0_nxt    = div_prod[DIV_K +: 8];
        state_nxt = ST_DIV1;
      end
      ST_DIV1: begin
        if (sat_r) begin
          res_nxt = 8'hFF;
        end else if (rem >= DIV_K'(area_r)) begin
          res_nxt = q0_r + 8'd1;
        end else begin
          res_nxt = q0_r;
        end
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_alpha_nxt = res_r;
          out_last_nxt  = frame_last_c;
          if (frame_last_c) begin
            in_col_nxt  = '0;
            in_row_nxt  = '0;
            in_lin_nxt  = '0;
            out_col_nxt = '0;
            out_row_nxt = '0;
            out_lin_nxt = '0;
            row_sum_nxt = '0;
          end else begin
            out_lin_nxt = out_lin_r + LIN_W'(1);
            if (DIM_W'(out_col_r) + DIM_ONE >= w_r) begin
              out_col_nxt = '0;
              out_row_nxt = out_row_r + DIM_ONE;
            end else begin
              out_col_nxt = out_col_r + COL_W'(1);
            end
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // a write to a known register restarts the frame
    if (cfg_wr && (paddr[3:2] == REG_BLUR || paddr[3:2] == REG_WIDTH ||
                   paddr[3:2] == REG_HEIGHT)) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      in_lin_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
      out_lin_nxt = '0;
      row_sum_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_col_r    <= '0;
      in_row_r    <= '0;
      in_lin_r    <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      out_lin_r   <= '0;
      row_sum_r   <= '0;
      acc_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_col_r    <= in_col_nxt;
      in_row_r    <= in_row_nxt;
      in_lin_r    <= in_lin_nxt;
      out_col_r   <= out_col_nxt;
      out_row_r   <= out_row_nxt;
      out_lin_r   <= out_lin_nxt;
      row_sum_r   <= row_sum_nxt;
      acc_vld_r   <= acc_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      op_r    <= in_opcode;
      alpha_r <= in_alpha_in;
    end
    dk2_r       <= dk2_nxt;
    di2_r       <= di2_nxt;
    has_k1_r    <= has_k1_nxt;
    has_i1_r    <= has_i1_nxt;
    rowoff_hi_r <= rowoff_hi_nxt;
    rd_idx_r    <= rd_idx_nxt;
    acc_idx_r   <= acc_idx_nxt;
    sum_r       <= sum_nxt;
    sat_r       <= sat_nxt;
    q0_r        <= q0_nxt;
    res_r       <= res_nxt;
    out_alpha_r <= out_alpha_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_alpha_out  = out_alpha_r;
  assign out_frame_last = out_last_r;

endmodule
